/* rtl/csi_motion_detector_unit_assert.svh */
// Assertion macros for the motion detector blocks.
// Expects clk and rst_n in the scope of the including module.
`ifndef CSI_MOTION_DETECTOR_UNIT_ASSERT_SVH
`define CSI_MOTION_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CSIMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSIMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/csimd_pkg.sv */
// Shared types, constants and helper functions of the motion detector.
// No dependencies; used by every module of the block.
package csimd_pkg;

  localparam int SUBCARRIERS_DEF = 256;

  localparam int ALPHA_W   = 9;
  localparam int THR_W     = 16;
  localparam int MS_W      = 16;
  localparam int SEC_W     = 7;
  localparam int SCORE_W   = 16;
  localparam int SUM_W     = 24;
  localparam int MAG_W     = 16;
  localparam int ACC_W     = 25;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int CNT_MAX_W = 11;   // divisor width, enough for 1024 pairs
  localparam int OPND_W    = 32;
  localparam int Q_W       = 24;
  localparam int SUB_W     = 20;   // trial subtractor width
  localparam int STEP_W    = 5;

  localparam logic [STEP_W-1:0] SQRT_STEPS = 5'd16;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 5'd24;

  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 9'd230;
  localparam logic [THR_W-1:0]   THRESH_RST  = 16'd512;
  localparam logic [MS_W-1:0]    CALIB_RST   = 16'd5000;
  localparam logic [MS_W-1:0]    REFRESH_RST = 16'd1000;
  localparam logic [MS_W-1:0]    TIMEOUT_RST = 16'd3000;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;
  localparam logic [MAG_W-1:0]   SMOOTH_FLOOR = 16'd25;
  localparam logic [SEC_W-1:0]   SEC_MAX      = 7'd65;
  localparam logic [ACC_W-1:0]   ROUND_HALF   = 25'd128;

  // floor(x / 1000) = (x * 67109) >> 26 for every 16-bit x
  localparam logic [16:0] RECIP_1000  = 17'd67109;
  localparam int          RECIP_SHIFT = 26;

  typedef enum logic [2:0] {
    REG_ALPHA,
    REG_THRESH,
    REG_CALIB,
    REG_REFRESH,
    REG_TIMEOUT
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_PAIR,
    MODE_TICK,
    MODE_START,
    MODE_STOP
  } mode_t;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PAIR,
    S_SQRT,
    S_MUL1,
    S_MUL2,
    S_WRITE,
    S_DIV,
    S_DIVW,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [THR_W-1:0]   thresh;
    logic [MS_W-1:0]    calib_ms;
    logic [MS_W-1:0]    refresh_ms;
    logic [MS_W-1:0]    timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    iter_op_t             op;
    logic [OPND_W-1:0]    operand;
    logic [CNT_MAX_W-1:0] divisor;
  } iter_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] result;
  } iter_rsp_t;

  function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] x);
    return (x == {MS_W{1'b1}}) ? x : x + 1'b1;
  endfunction

  function automatic logic [SEC_W-1:0] div1000(input logic [MS_W-1:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(RECIP_1000);
    return p[RECIP_SHIFT +: SEC_W];
  endfunction

endpackage

/* rtl/csimd_cfg_regs.sv */
// APB-style configuration register file of the motion detector.
// Depends on csimd_pkg.
module csimd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [csimd_pkg::PADDR_W-1:0]    paddr,
  input  logic [csimd_pkg::PDATA_W-1:0]    pwdata,
  output logic [csimd_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready,
  output csimd_pkg::cfg_t                  cfg
);

  csimd_pkg::cfg_t      cfg_r;
  csimd_pkg::reg_idx_t  idx;
  logic                 wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = csimd_pkg::reg_idx_t'(paddr[csimd_pkg::PADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha      <= csimd_pkg::ALPHA_RST;
      cfg_r.thresh     <= csimd_pkg::THRESH_RST;
      cfg_r.calib_ms   <= csimd_pkg::CALIB_RST;
      cfg_r.refresh_ms <= csimd_pkg::REFRESH_RST;
      cfg_r.timeout_ms <= csimd_pkg::TIMEOUT_RST;
    end else if (wr) begin
      case (idx)
        csimd_pkg::REG_ALPHA:   cfg_r.alpha      <= pwdata[csimd_pkg::ALPHA_W-1:0];
        csimd_pkg::REG_THRESH:  cfg_r.thresh     <= pwdata[csimd_pkg::THR_W-1:0];
        csimd_pkg::REG_CALIB:   cfg_r.calib_ms   <= pwdata[csimd_pkg::MS_W-1:0];
        csimd_pkg::REG_REFRESH: cfg_r.refresh_ms <= pwdata[csimd_pkg::MS_W-1:0];
        csimd_pkg::REG_TIMEOUT: cfg_r.timeout_ms <= pwdata[csimd_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      csimd_pkg::REG_ALPHA:   prdata = csimd_pkg::PDATA_W'(cfg_r.alpha);
      csimd_pkg::REG_THRESH:  prdata = csimd_pkg::PDATA_W'(cfg_r.thresh);
      csimd_pkg::REG_CALIB:   prdata = csimd_pkg::PDATA_W'(cfg_r.calib_ms);
      csimd_pkg::REG_REFRESH: prdata = csimd_pkg::PDATA_W'(cfg_r.refresh_ms);
      csimd_pkg::REG_TIMEOUT: prdata = csimd_pkg::PDATA_W'(cfg_r.timeout_ms);
      default:                prdata = '0;
    endcase
  end

endmodule

/* rtl/csimd_iter_unit.sv */
// Shared trial-subtract unit: bit-serial square root and restoring division.
// Depends on csimd_pkg.
module csimd_iter_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csimd_pkg::iter_req_t  req,
  output csimd_pkg::iter_rsp_t  rsp
);

  localparam int SW = csimd_pkg::SUB_W;

  logic                                busy_r;
  logic                                done_r;
  csimd_pkg::iter_op_t                 op_r;
  logic [csimd_pkg::OPND_W-1:0]        src_r;
  logic [SW-1:0]                       rem_r;
  logic [csimd_pkg::Q_W-1:0]           q_r;
  logic [csimd_pkg::STEP_W-1:0]        cnt_r;
  logic [csimd_pkg::CNT_MAX_W-1:0]     div_r;

  logic [SW-1:0]                       trial_a;
  logic [SW-1:0]                       trial_b;
  logic [SW:0]                         diff;
  logic                                ge;
  logic [csimd_pkg::OPND_W-1:0]        src_nxt;

  // square root brings in two bits a step against 4*root+1,
  // division one bit a step against the divisor
  always_comb begin
    case (op_r)
      csimd_pkg::OP_SQRT: begin
        trial_a = {rem_r[SW-3:0], src_r[csimd_pkg::OPND_W-1 -: 2]};
        trial_b = {q_r[SW-3:0], 2'b01};
        src_nxt = {src_r[csimd_pkg::OPND_W-3:0], 2'b00};
      end
      default: begin
        trial_a = {rem_r[SW-2:0], src_r[csimd_pkg::OPND_W-1]};
        trial_b = {{(SW-csimd_pkg::CNT_MAX_W){1'b0}}, div_r};
        src_nxt = {src_r[csimd_pkg::OPND_W-2:0], 1'b0};
      end
    endcase
    diff = {1'b0, trial_a} - {1'b0, trial_b};
    ge   = ~diff[SW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == csimd_pkg::OP_SQRT) ? csimd_pkg::SQRT_STEPS - 1'b1
                                                 : csimd_pkg::DIV_STEPS - 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      src_r <= req.operand;
      div_r <= req.divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      src_r <= src_nxt;
      rem_r <= ge ? diff[SW-1:0] : trial_a;
      q_r   <= {q_r[csimd_pkg::Q_W-2:0], ge};
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = q_r;

endmodule

/* rtl/csimd_amp_store.sv */
// Smoothed amplitude memory, one Q8.8 word per subcarrier.
// One write port, one registered read port. Depends on csimd_pkg.
module csimd_amp_store #(
  parameter int DEPTH = csimd_pkg::SUBCARRIERS_DEF,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [csimd_pkg::MAG_W-1:0]   wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [csimd_pkg::MAG_W-1:0]   rdata
);

  logic [csimd_pkg::MAG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/csimd_seq.sv */
// Sequencer of the motion detector: item handshake, detector state, frame
// accumulation and output register. Depends on csimd_pkg and the assert header.
`include "csi_motion_detector_unit_assert.svh"

module csimd_seq #(
  parameter int SUBCARRIERS = csimd_pkg::SUBCARRIERS_DEF,
  parameter int AW          = 8,
  parameter int CW          = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csimd_pkg::cfg_t               cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  input  logic [3:0]                    in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,
  output logic                          out_tuser,
  output csimd_pkg::iter_req_t          iter_req,
  input  csimd_pkg::iter_rsp_t          iter_rsp,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [csimd_pkg::MAG_W-1:0]   mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [csimd_pkg::MAG_W-1:0]   mem_rdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(SUBCARRIERS - 1);
  localparam logic [CW-1:0] CNT_LIM  = CW'(SUBCARRIERS);

  csimd_pkg::seq_state_t state_r, state_nxt;

  logic                               active_r, active_nxt;
  logic                               calib_r, calib_nxt;
  logic [csimd_pkg::MS_W-1:0]         cel_r, cel_nxt;
  logic [csimd_pkg::MS_W-1:0]         rel_r, rel_nxt;
  logic [csimd_pkg::SEC_W-1:0]        sec_r, sec_nxt;
  logic                               motion_r, motion_nxt;
  logic [csimd_pkg::MS_W-1:0]         age_r, age_nxt;
  logic [csimd_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic [AW-1:0]                      clr_idx_r, clr_idx_nxt;
  logic                               clr_emit_r, clr_emit_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic signed [7:0]                  im_r, im_nxt;
  logic signed [7:0]                  re_r, re_nxt;
  logic                               last_r, last_nxt;
  logic [csimd_pkg::MAG_W-1:0]        mag_r, mag_nxt;
  logic [csimd_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [csimd_pkg::SCORE_W-1:0]      score_r, score_nxt;
  logic                               valid_r, valid_nxt;
  logic [31:0]                        out_data_r;
  logic                               out_user_r;
  logic                               out_load;

  csimd_pkg::mode_t                   in_mode;
  logic                               in_fs;
  logic                               in_fi;
  logic [CW-1:0]                      cnt_base;
  logic [csimd_pkg::MS_W-1:0]         cel_inc;
  logic [csimd_pkg::MS_W-1:0]         rel_inc;
  logic [csimd_pkg::MS_W-1:0]         age_inc;
  logic [csimd_pkg::ALPHA_W-1:0]      alpha_c;
  logic [csimd_pkg::MAG_W-1:0]        mul_x;
  logic [csimd_pkg::ALPHA_W-1:0]      mul_y;
  logic [csimd_pkg::ACC_W-1:0]        prod;
  logic signed [15:0]                 im_sq;
  logic signed [15:0]                 re_sq;
  logic [15:0]                        pw;
  logic [csimd_pkg::MAG_W-1:0]        adiff;
  logic [csimd_pkg::SUM_W:0]          sum_add;
  logic [csimd_pkg::SCORE_W-1:0]      score_sat;

  assign in_mode  = csimd_pkg::mode_t'(in_tuser[1:0]);
  assign in_fs    = in_tuser[2];
  assign in_fi    = in_tuser[3];
  assign cnt_base = in_fs ? '0 : cnt_r;
  assign cel_inc  = csimd_pkg::sat_inc(cel_r);
  assign rel_inc  = csimd_pkg::sat_inc(rel_r);
  assign age_inc  = csimd_pkg::sat_inc(age_r);
  assign alpha_c  = (cfg.alpha > csimd_pkg::ALPHA_ONE) ? csimd_pkg::ALPHA_ONE : cfg.alpha;

  // one multiplier, shared by both halves of the low-pass update
  assign mul_x = (state_r == csimd_pkg::S_MUL1) ? mem_rdata : mag_r;
  assign mul_y = (state_r == csimd_pkg::S_MUL1) ? alpha_c : csimd_pkg::ALPHA_ONE - alpha_c;
  assign prod  = csimd_pkg::ACC_W'(mul_x) * csimd_pkg::ACC_W'(mul_y);

  assign im_sq   = im_r * im_r;
  assign re_sq   = re_r * re_r;
  assign pw      = 16'(im_sq) + 16'(re_sq);
  assign adiff   = (mag_r > mem_rdata) ? mag_r - mem_rdata : mem_rdata - mag_r;
  assign sum_add = {1'b0, sum_r} + (csimd_pkg::SUM_W + 1)'(adiff);
  assign score_sat = (|iter_rsp.result[csimd_pkg::Q_W-1:csimd_pkg::SCORE_W]) ?
                     {csimd_pkg::SCORE_W{1'b1}} : iter_rsp.result[csimd_pkg::SCORE_W-1:0];

  assign in_tready = (state_r == csimd_pkg::S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    calib_nxt    = calib_r;
    cel_nxt      = cel_r;
    rel_nxt      = rel_r;
    sec_nxt      = sec_r;
    motion_nxt   = motion_r;
    age_nxt      = age_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    clr_idx_nxt  = clr_idx_r;
    clr_emit_nxt = clr_emit_r;
    im_nxt       = im_r;
    re_nxt       = re_r;
    last_nxt     = last_r;
    mag_nxt      = mag_r;
    acc_nxt      = acc_r;
    score_nxt    = score_r;
    valid_nxt    = valid_r;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = clr_idx_r;
    mem_wdata    = '0;
    mem_raddr    = cnt_r[AW-1:0];
    iter_req     = '{start: 1'b0, op: csimd_pkg::OP_SQRT, operand: '0, divisor: '0};

    case (state_r)
      csimd_pkg::S_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          clr_idx_nxt = '0;
          state_nxt   = clr_emit_r ? csimd_pkg::S_EMIT : csimd_pkg::S_IDLE;
        end
      end

      csimd_pkg::S_IDLE: begin
        if (in_tvalid) begin
          score_nxt = '0;
          valid_nxt = 1'b0;
          state_nxt = csimd_pkg::S_EMIT;
          case (in_mode)
            csimd_pkg::MODE_PAIR: begin
              if (active_r) begin
                im_nxt   = in_tdata[7:0];
                re_nxt   = in_tdata[15:8];
                last_nxt = in_tlast;
                cnt_nxt  = cnt_base;
                if (in_fs) begin
                  sum_nxt = '0;
                end
                if (!(in_fs && in_fi) && cnt_base < CNT_LIM) begin
                  state_nxt = csimd_pkg::S_PAIR;
                end else if (in_tlast) begin
                  state_nxt = csimd_pkg::S_DIV;
                end
              end
            end
            csimd_pkg::MODE_TICK: begin
              if (calib_r) begin
                cel_nxt = cel_inc;
                rel_nxt = rel_inc;
                if (cel_inc >= cfg.calib_ms) begin
                  calib_nxt = 1'b0;
                  sec_nxt   = '0;
                end else if (rel_inc >= cfg.refresh_ms) begin
                  rel_nxt = '0;
                  sec_nxt = csimd_pkg::div1000(cfg.calib_ms - cel_inc);
                end
              end
              if (motion_r) begin
                age_nxt = age_inc;
                if (age_inc > cfg.timeout_ms) begin
                  motion_nxt = 1'b0;
                end
              end
            end
            csimd_pkg::MODE_START: begin
              active_nxt   = 1'b1;
              calib_nxt    = 1'b1;
              cel_nxt      = '0;
              rel_nxt      = '0;
              sec_nxt      = csimd_pkg::div1000(cfg.calib_ms);
              motion_nxt   = 1'b0;
              age_nxt      = '0;
              sum_nxt      = '0;
              cnt_nxt      = '0;
              clr_idx_nxt  = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = csimd_pkg::S_CLEAR;
            end
            default: begin
              active_nxt = 1'b0;
              calib_nxt  = 1'b0;
              motion_nxt = 1'b0;
            end
          endcase
        end
      end

      csimd_pkg::S_PAIR: begin
        iter_req.start   = 1'b1;
        iter_req.op      = csimd_pkg::OP_SQRT;
        iter_req.operand = {pw, 16'h0000};
        state_nxt        = csimd_pkg::S_SQRT;
      end

      csimd_pkg::S_SQRT: begin
        if (iter_rsp.done) begin
          mag_nxt   = iter_rsp.result[csimd_pkg::MAG_W-1:0];
          state_nxt = csimd_pkg::S_MUL1;
        end
      end

      csimd_pkg::S_MUL1: begin
        acc_nxt = prod;
        // only settled subcarriers count towards the change
        if (mem_rdata > csimd_pkg::SMOOTH_FLOOR) begin
          sum_nxt = sum_add[csimd_pkg::SUM_W] ? {csimd_pkg::SUM_W{1'b1}}
                                              : sum_add[csimd_pkg::SUM_W-1:0];
        end
        state_nxt = csimd_pkg::S_MUL2;
      end

      csimd_pkg::S_MUL2: begin
        acc_nxt   = acc_r + prod + csimd_pkg::ROUND_HALF;
        state_nxt = csimd_pkg::S_WRITE;
      end

      csimd_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = acc_r[8 +: csimd_pkg::MAG_W];
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? csimd_pkg::S_DIV : csimd_pkg::S_EMIT;
      end

      csimd_pkg::S_DIV: begin
        if (cnt_r != '0) begin
          iter_req.start   = 1'b1;
          iter_req.op      = csimd_pkg::OP_DIV;
          iter_req.operand = {sum_r, 8'h00};
          iter_req.divisor = csimd_pkg::CNT_MAX_W'(cnt_r);
          state_nxt        = csimd_pkg::S_DIVW;
        end else begin
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = csimd_pkg::S_EMIT;
        end
      end

      csimd_pkg::S_DIVW: begin
        if (iter_rsp.done) begin
          score_nxt = score_sat;
          valid_nxt = 1'b1;
          if (!calib_r && score_sat > cfg.thresh) begin
            motion_nxt = 1'b1;
            age_nxt    = '0;
          end
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = csimd_pkg::S_EMIT;
        end
      end

      csimd_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = csimd_pkg::S_IDLE;
        end
      end

      default: state_nxt = csimd_pkg::S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csimd_pkg::S_CLEAR;
      active_r    <= 1'b0;
      calib_r     <= 1'b0;
      cel_r       <= '0;
      rel_r       <= '0;
      sec_r       <= '0;
      motion_r    <= 1'b0;
      age_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      clr_idx_r   <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      calib_r     <= calib_nxt;
      cel_r       <= cel_nxt;
      rel_r       <= rel_nxt;
      sec_r       <= sec_nxt;
      motion_r    <= motion_nxt;
      age_r       <= age_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    im_r    <= im_nxt;
    re_r    <= re_nxt;
    last_r  <= last_nxt;
    mag_r   <= mag_nxt;
    acc_r   <= acc_nxt;
    score_r <= score_nxt;
    valid_r <= valid_nxt;
    if (out_load) begin
      out_data_r <= {6'b000000, score_r, motion_r, sec_r, calib_r, active_r};
      out_user_r <= valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `CSIMD_ASSERT_IMP(a_no_motion_in_calib, calib_r, !motion_r, "motion set during calibration")
  `CSIMD_ASSERT_IMP(a_calib_needs_active, calib_r, active_r, "calibrating while inactive")
  `CSIMD_ASSERT_NXT(a_one_word_at_a_time, in_tvalid && in_tready, !in_tready, "second word taken")
  `CSIMD_ASSERT_IMP(a_frame_cnt_bound, 1'b1, cnt_r <= CNT_LIM, "pair count past subcarriers")
  `CSIMD_ASSERT_IMP(a_seconds_range, 1'b1, sec_r <= csimd_pkg::SEC_MAX, "seconds out of range")

endmodule

/* rtl/csi_motion_detector_unit.sv */
// Motion detector on channel-state amplitude variation. Words are taken one at
// a time. An I/Q pair holds the block while the shared trial-subtract unit
// runs 16 square-root steps, followed by two multiply steps, the amplitude
// write and the loading of its result word. The last pair of a frame also
// runs the 24-step mean division in the same unit. Ticks, stops and pairs
// while inactive go straight to the result word. A start word clears the
// amplitude memory one entry a cycle and then emits a result word. The same
// clearing pass runs after reset before the first word is taken. A result
// word that has not been taken holds the block, and the input waits meanwhile.
// Configuration writes are accepted at any time.
module csi_motion_detector_unit #(
  parameter int SUBCARRIERS = csimd_pkg::SUBCARRIERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // imag[7:0], real_req[15:8]
  input  logic [3:0]                     in_tuser,   // mode[1:0], frame_start[2], first_invalid[3]
  input  logic                           in_tlast,   // last_in_frame
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // active[0], calibrating[1],
                                                     // seconds_left[8:2], motion[9],
                                                     // frame_score[25:10], zero[31:26]
  output logic                           out_tuser,  // score_valid
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csimd_pkg::PADDR_W-1:0]  paddr,
  input  logic [csimd_pkg::PDATA_W-1:0]  pwdata,
  output logic [csimd_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  localparam int AW = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1;
  localparam int CW = $clog2(SUBCARRIERS + 1);

  csimd_pkg::cfg_t       cfg;
  csimd_pkg::iter_req_t  iter_req;
  csimd_pkg::iter_rsp_t  iter_rsp;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [csimd_pkg::MAG_W-1:0]   mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [csimd_pkg::MAG_W-1:0]   mem_rdata;

  csimd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csimd_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .rsp   (iter_rsp)
  );

  csimd_amp_store #(
    .DEPTH (SUBCARRIERS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  csimd_seq #(
    .SUBCARRIERS (SUBCARRIERS),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .iter_req   (iter_req),
    .iter_rsp   (iter_rsp),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule
